// ===== hdl/desktop_size_string_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Desktop size string parser assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef DESKTOP_SIZE_STRING_PARSER_ASSERT_SVH
`define DESKTOP_SIZE_STRING_PARSER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DSSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DSSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Desktop size string parser package
// Constants, codes and types shared by the parser and its channel interfaces.
// ----------------------------------------------------------------------------
package dssp_pkg;

	localparam int MAX_STRICT_LENGTH = 32;
	localparam int MAX_DIMENSION     = 65535;

	localparam int CHAR_W  = 8;
	localparam int SIZE_W  = 16;
	localparam int COUNT_W = 6;
	localparam int ACC_W   = $clog2(MAX_DIMENSION + 1);
	localparam int DIM_W   = (ACC_W > SIZE_W) ? ACC_W : SIZE_W;
	localparam int PROD_W  = DIM_W + 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

	typedef enum logic [0:0] {
		OP_CHAR = 1'b0,
		OP_END  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_VALID   = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		PH_PRE1  = 7'b0000001,
		PH_PLUS1 = 7'b0000010,
		PH_DIG1  = 7'b0000100,
		PH_PRE2  = 7'b0001000,
		PH_PLUS2 = 7'b0010000,
		PH_DIG2  = 7'b0100000,
		PH_TAIL  = 7'b1000000
	} phase_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// ===== hdl/dssp_in_if.sv =====
// ----------------------------------------------------------------------------
// Desktop size string parser input channel
// Valid/ready channel carrying one character or an end-of-string mark.
// ----------------------------------------------------------------------------
interface dssp_in_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [dssp_pkg::CHAR_W-1:0] ch;

	modport source (output valid, output op, output ch, input ready);
	modport sink (input valid, input op, input ch, output ready);
endinterface

// ===== hdl/dssp_out_if.sv =====
// ----------------------------------------------------------------------------
// Desktop size string parser output channel
// Valid/ready channel carrying the parse status and the two sizes.
// ----------------------------------------------------------------------------
interface dssp_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [dssp_pkg::SIZE_W-1:0] width_out;
	logic [dssp_pkg::SIZE_W-1:0] height_out;

	modport source (output valid, output status, output width_out, output height_out,
		input ready);
	modport sink (input valid, input status, input width_out, input height_out,
		output ready);
endinterface

// ===== hdl/desktop_size_string_parser.sv =====
// ----------------------------------------------------------------------------
// Desktop size string parser
// Parses WIDTHxHEIGHT one character per transaction and reports the sizes
// on the end-of-string transaction.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                            handshake
//  --------  ---  ---------------------------------  ------------------------
//  in_item   in   op, ch                             valid / ready
//  out_item  out  status, width_out, height_out      valid / ready
//  cfg       in   cfg_data (syntax_mode)             cfg_write, no wait
//
//  One transaction per cycle: each character updates the parse state in the
//  cycle it is accepted, through one multiply-by-ten-and-add on the running
//  value. An end-of-string transaction loads the result register; the result
//  is offered the next cycle. Input ready drops only while a result waits and
//  the sink holds it off. Reset (arst_n low) clears the parse state, the mode
//  (legacy) and the result valid flag.
//
module desktop_size_string_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_data,
	dssp_in_if.sink     in_item,
	dssp_out_if.source  out_item
);

	`include "desktop_size_string_parser_assert.svh"

	// Syntax mode register: 0 legacy, 1 strict
	logic strict_q;

	// Parse state
	dssp_pkg::phase_t                   phase_q, phase_d;
	logic [dssp_pkg::DIM_W-1:0]         acc_q, acc_d;
	logic [dssp_pkg::DIM_W-1:0]         first_q, first_d;
	logic                               seen_q, seen_d;
	logic [dssp_pkg::COUNT_W-1:0]       count_q, count_d;
	logic                               err_q, err_d;

	// Result register
	logic                               out_valid_q;
	dssp_pkg::status_t                  status_q, status_d;
	logic [dssp_pkg::SIZE_W-1:0]        width_q, width_d;
	logic [dssp_pkg::SIZE_W-1:0]        height_q, height_d;

	logic                               in_fire;
	logic                               out_fire;
	logic                               end_fire;
	logic                               char_fire;
	logic                               digit;
	logic                               blank;
	logic [dssp_pkg::DIM_W-1:0]         mul_src;
	logic [dssp_pkg::PROD_W-1:0]        prod;
	logic                               over;
	logic                               size_ok;

	// Accept a transaction whenever the result slot is free or being emptied
	assign in_item.ready = !out_valid_q || out_item.ready;
	assign in_fire   = in_item.valid && in_item.ready;
	assign out_fire  = out_item.valid && out_item.ready;
	assign end_fire  = in_fire && (in_item.op == dssp_pkg::OP_END);
	assign char_fire = in_fire && (in_item.op == dssp_pkg::OP_CHAR);

	assign digit = dssp_pkg::is_digit(in_item.ch);
	assign blank = dssp_pkg::is_blank(in_item.ch);

	// A number starts from zero outside the digit phases
	assign mul_src = ((phase_q == dssp_pkg::PH_DIG1) || (phase_q == dssp_pkg::PH_DIG2))
		? acc_q : '0;

	// Running value times ten plus the new digit
	assign prod = ({4'b0, mul_src} << 3) + ({4'b0, mul_src} << 1)
		+ dssp_pkg::PROD_W'(in_item.ch[3:0]);
	assign over = prod > dssp_pkg::PROD_W'(dssp_pkg::MAX_DIMENSION);

	// Next parse state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		first_d = first_q;
		seen_d  = seen_q;
		count_d = count_q;
		err_d   = err_q;

		if (char_fire) begin
			if (count_q != dssp_pkg::COUNT_MAX) begin
				count_d = count_q + 1'b1;
			end
			// Count characters after an error, otherwise drop them
			if (!err_q) begin
				unique case (phase_q)
					dssp_pkg::PH_PRE1, dssp_pkg::PH_PRE2: begin
						if (digit) begin
							acc_d  = prod[dssp_pkg::DIM_W-1:0];
							seen_d = 1'b1;
							err_d  = over;
							phase_d = (phase_q == dssp_pkg::PH_PRE1)
								? dssp_pkg::PH_DIG1 : dssp_pkg::PH_DIG2;
						end else if (!strict_q && blank) begin
							phase_d = phase_q;
						end else if (!strict_q && (in_item.ch == dssp_pkg::CH_PLUS)) begin
							phase_d = (phase_q == dssp_pkg::PH_PRE1)
								? dssp_pkg::PH_PLUS1 : dssp_pkg::PH_PLUS2;
						end else begin
							err_d = 1'b1;
						end
					end
					dssp_pkg::PH_PLUS1, dssp_pkg::PH_PLUS2: begin
						if (digit) begin
							acc_d  = prod[dssp_pkg::DIM_W-1:0];
							seen_d = 1'b1;
							err_d  = over;
							phase_d = (phase_q == dssp_pkg::PH_PLUS1)
								? dssp_pkg::PH_DIG1 : dssp_pkg::PH_DIG2;
						end else begin
							err_d = 1'b1;
						end
					end
					dssp_pkg::PH_DIG1: begin
						if (digit) begin
							acc_d  = prod[dssp_pkg::DIM_W-1:0];
							seen_d = 1'b1;
							err_d  = over;
						end else if ((in_item.ch == dssp_pkg::CH_X) && seen_q
							&& (acc_q != '0)) begin
							// Hold the width, restart for the height
							first_d = acc_q;
							acc_d   = '0;
							seen_d  = 1'b0;
							phase_d = dssp_pkg::PH_PRE2;
						end else begin
							err_d = 1'b1;
						end
					end
					dssp_pkg::PH_DIG2: begin
						if (digit) begin
							acc_d  = prod[dssp_pkg::DIM_W-1:0];
							seen_d = 1'b1;
							err_d  = over;
						end else if (!strict_q) begin
							phase_d = dssp_pkg::PH_TAIL;
						end else begin
							err_d = 1'b1;
						end
					end
					dssp_pkg::PH_TAIL: begin
						// Legacy ignores the trailing text, strict rejects it
						err_d = strict_q;
					end
					default: begin
						err_d = 1'b1;
					end
				endcase
			end
		end

		// Clear for the next string after every end transaction
		if (end_fire) begin
			phase_d = dssp_pkg::PH_PRE1;
			acc_d   = '0;
			first_d = '0;
			seen_d  = 1'b0;
			count_d = '0;
			err_d   = 1'b0;
		end
	end

	// Final verdict, evaluated on the end transaction
	assign size_ok = !err_q
		&& ((phase_q == dssp_pkg::PH_DIG2) || ((phase_q == dssp_pkg::PH_TAIL) && !strict_q))
		&& (acc_q != '0)
		&& !(strict_q && (count_q > dssp_pkg::COUNT_W'(dssp_pkg::MAX_STRICT_LENGTH)));

	always_comb begin
		status_d = dssp_pkg::STATUS_INVALID;
		width_d  = '0;
		height_d = '0;
		if (count_q == '0) begin
			status_d = dssp_pkg::STATUS_EMPTY;
		end else if (size_ok) begin
			status_d = dssp_pkg::STATUS_VALID;
			width_d  = first_q[dssp_pkg::SIZE_W-1:0];
			height_d = acc_q[dssp_pkg::SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
		end else if (cfg_write) begin
			strict_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dssp_pkg::PH_PRE1;
			acc_q   <= '0;
			first_q <= '0;
			seen_q  <= 1'b0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			first_q <= first_d;
			seen_q  <= seen_d;
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

	// Result valid: set on an end transaction, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (end_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire) begin
			status_q <= status_d;
			width_q  <= width_d;
			height_q <= height_d;
		end
	end

	assign out_item.valid      = out_valid_q;
	assign out_item.status     = status_q;
	assign out_item.width_out  = width_q;
	assign out_item.height_out = height_q;

	`DSSP_ASSERT_NEXT(a_end_gives_result, end_fire, out_valid_q, "end transaction gave no result")
	`DSSP_ASSERT_NEXT(a_end_clears_state, end_fire,
		(phase_q == dssp_pkg::PH_PRE1) && (count_q == '0) && !err_q, "state not cleared after end")
	`DSSP_ASSERT_NEXT(a_error_sticks, err_q && !end_fire, err_q, "error dropped before end")
	`DSSP_ASSERT_NOW(a_sizes_zero, out_valid_q && (status_q != dssp_pkg::STATUS_VALID),
		(width_q == '0) && (height_q == '0), "sizes not zero on a non-valid status")

endmodule
